FILE: design/matrix_multiply_defines.svh
// ---------------------------------------------------------------------------
// matrix_multiply_defines
// Assertion macros used by the matrix multiply engine (mm_engine).
// ---------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/mm_pkg.sv
// ---------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the matrix multiply block.
// ---------------------------------------------------------------------------
package mm_pkg;

	localparam int DIM_W   = 4;
	localparam int IDX_W   = 3;
	localparam int VALUE_W = 35;
	localparam int TOT_W   = 2 * DIM_W + 1;

	localparam logic [1:0] REG_ROWS_A    = 2'd0;
	localparam logic [1:0] REG_INNER_DIM = 2'd1;
	localparam logic [1:0] REG_COLS_B    = 2'd2;

	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] inner;
		logic [DIM_W-1:0] cols;
	} dims_t;

	typedef struct packed {
		logic             first;
		logic             fin;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} tag_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		if (v < DIM_W'(2)) begin
			r = DIM_W'(2);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: design/mm_ram.sv
// ---------------------------------------------------------------------------
// mm_ram
// Element store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module mm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/mm_engine.sv
// ---------------------------------------------------------------------------
// mm_engine
// Sequencer and multiply-accumulate: walks i, j, t, reads A and B stores,
// multiplies, accumulates and registers one result per dot product.
// ---------------------------------------------------------------------------
`include "matrix_multiply_defines.svh"

module mm_engine #(
	parameter int MAX_DIM       = 8,
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  mm_pkg::dims_t                         dims,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    a_addr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    b_addr,
	input  logic signed [ELEMENT_WIDTH-1:0]       a_data,
	input  logic signed [ELEMENT_WIDTH-1:0]       b_data,
	output logic                                  out_valid,
	output logic signed [mm_pkg::VALUE_W-1:0]     product_value,
	output logic [mm_pkg::IDX_W-1:0]              out_row,
	output logic [mm_pkg::IDX_W-1:0]              out_col,
	output logic                                  last
);

	localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
	localparam int IW    = $clog2(MAX_DIM);
	localparam int PW    = 2 * ELEMENT_WIDTH;
	localparam int ACC_W = PW + $clog2(MAX_DIM);
	localparam int SUM_W = (ACC_W > mm_pkg::VALUE_W) ? ACC_W : mm_pkg::VALUE_W;

	logic                    run_q;
	logic [IW-1:0]           i_q, j_q, t_q;
	logic [AW-1:0]           a_base_q, b_addr_q;
	logic [mm_pkg::DIM_W-1:0] rmax, kmax, cmax;
	logic                    t_end, j_end, i_end;
	mm_pkg::tag_t            tag_now;

	logic                    valid_s1, valid_s2;
	mm_pkg::tag_t            tag_s1, tag_s2;
	logic signed [PW-1:0]    prod_s2;
	logic signed [ACC_W-1:0] acc_q, sum;
	logic signed [SUM_W-1:0] sum_ext;

	logic                             out_valid_q, out_last_q;
	logic signed [mm_pkg::VALUE_W-1:0] out_value_q;
	logic [mm_pkg::IDX_W-1:0]         out_row_q, out_col_q;

	assign rmax  = dims.rows - 1'b1;
	assign kmax  = dims.inner - 1'b1;
	assign cmax  = dims.cols - 1'b1;
	assign t_end = mm_pkg::DIM_W'(t_q) == kmax;
	assign j_end = mm_pkg::DIM_W'(j_q) == cmax;
	assign i_end = mm_pkg::DIM_W'(i_q) == rmax;

	assign a_addr = a_base_q + AW'(t_q);
	assign b_addr = b_addr_q;

	always_comb begin
		tag_now.first = t_q == '0;
		tag_now.fin   = t_end;
		tag_now.last  = t_end && j_end && i_end;
		tag_now.row   = mm_pkg::IDX_W'(i_q);
		tag_now.col   = mm_pkg::IDX_W'(j_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			t_q      <= '0;
			a_base_q <= '0;
			b_addr_q <= '0;
		end else if (start) begin
			run_q    <= 1'b1;
			i_q      <= '0;
			j_q      <= '0;
			t_q      <= '0;
			a_base_q <= '0;
			b_addr_q <= '0;
		end else if (run_q) begin
			if (!t_end) begin
				t_q      <= t_q + 1'b1;
				b_addr_q <= b_addr_q + AW'(dims.cols);
			end else begin
				t_q <= '0;
				if (!j_end) begin
					j_q      <= j_q + 1'b1;
					b_addr_q <= AW'(j_q) + AW'(1);
				end else begin
					j_q      <= '0;
					b_addr_q <= '0;
					if (!i_end) begin
						i_q      <= i_q + 1'b1;
						a_base_q <= a_base_q + AW'(dims.inner);
					end else begin
						run_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= run_q;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2 && tag_s2.fin;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= tag_now;
		tag_s2  <= tag_s1;
		prod_s2 <= a_data * b_data;
		if (valid_s2) begin
			acc_q <= sum;
		end
		if (valid_s2 && tag_s2.fin) begin
			out_value_q <= sum_ext[mm_pkg::VALUE_W-1:0];
			out_row_q   <= tag_s2.row;
			out_col_q   <= tag_s2.col;
			out_last_q  <= tag_s2.last;
		end
	end

	assign sum     = tag_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
	assign sum_ext = SUM_W'(sum);

	assign out_valid     = out_valid_q;
	assign product_value = out_value_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign last          = out_last_q;

	`MM_ASSERT_NOW(a_start_idle, start, !run_q && !valid_s1 && !valid_s2, "start while computing")
	`MM_ASSERT_NOW(a_last_drained, out_valid_q && out_last_q, !run_q && !valid_s1, "work after last result")
	`MM_ASSERT_NOW(a_row_range, out_valid_q, mm_pkg::DIM_W'(out_row_q) < dims.rows, "row out of range")
	`MM_ASSERT_NEXT(a_run_stops, run_q && t_end && j_end && i_end && !start, !run_q, "run did not stop")

endmodule

FILE: design/matrix_multiply.sv
// ---------------------------------------------------------------------------
// matrix_multiply
// C = A * B over signed fixed-point elements held in two element stores.
//
// Usage: program rows_a, inner_dim and cols_b over the APB port (byte
// addresses 0, 4, 8) while the block is idle; values below 2 act as 2 and
// above MAX_DIM as MAX_DIM. A write to one of them restarts the load with A.
// Feed elements on element with start high; a transfer happens on each edge
// with start high and busy low: A row-major, then B row-major, one element
// per cycle. The transfer of the last B element raises busy. The engine then
// reads one A and one B element per cycle from the stores and runs one
// multiply-accumulate per cycle, giving one result per dot product. Each
// result is on the result ports for one cycle with out_valid high,
// row-major, last marking the final one. busy drops the cycle after that.
// The receiver cannot stall. Reset clears registers to 8 and the load
// position to zero; the element stores are not cleared.
// ---------------------------------------------------------------------------
module matrix_multiply #(
	parameter int MAX_DIM       = 8,
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [3:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              start,
	input  logic signed [ELEMENT_WIDTH-1:0]   element,
	output logic                              busy,
	output logic                              out_valid,
	output logic signed [mm_pkg::VALUE_W-1:0] product_value,
	output logic [mm_pkg::IDX_W-1:0]          out_row,
	output logic [mm_pkg::IDX_W-1:0]          out_col,
	output logic                              last
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = $clog2(2 * DEPTH);

	logic [mm_pkg::DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [LW-1:0]            load_count_q;
	logic                     busy_q;
	logic                     cfg_wr, accept, final_elem;
	mm_pkg::dims_t            dims;
	logic [mm_pkg::TOT_W-1:0] size_a, total, pos, bpos;
	logic                     we_a, we_b;
	logic [AW-1:0]            a_raddr, b_raddr;
	logic signed [ELEMENT_WIDTH-1:0] a_rdata, b_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			mm_pkg::REG_ROWS_A:    prdata = 32'(rows_a_q);
			mm_pkg::REG_INNER_DIM: prdata = 32'(inner_dim_q);
			mm_pkg::REG_COLS_B:    prdata = 32'(cols_b_q);
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		dims.rows  = mm_pkg::clamp_dim(rows_a_q, mm_pkg::DIM_W'(MAX_DIM));
		dims.inner = mm_pkg::clamp_dim(inner_dim_q, mm_pkg::DIM_W'(MAX_DIM));
		dims.cols  = mm_pkg::clamp_dim(cols_b_q, mm_pkg::DIM_W'(MAX_DIM));
	end

	assign size_a     = mm_pkg::TOT_W'(dims.rows * dims.inner);
	assign total      = size_a + mm_pkg::TOT_W'(dims.inner * dims.cols);
	assign pos        = (mm_pkg::TOT_W'(load_count_q) >= total) ? '0
		: mm_pkg::TOT_W'(load_count_q);
	assign bpos       = pos - size_a;
	assign accept     = start && !busy_q;
	assign final_elem = (pos + 1'b1) == total;
	assign we_a       = accept && (pos < size_a);
	assign we_b       = accept && !(pos < size_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q     <= mm_pkg::DIM_W'(8);
			inner_dim_q  <= mm_pkg::DIM_W'(8);
			cols_b_q     <= mm_pkg::DIM_W'(8);
			load_count_q <= '0;
			busy_q       <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					mm_pkg::REG_ROWS_A: begin
						rows_a_q     <= pwdata[mm_pkg::DIM_W-1:0];
						load_count_q <= '0;
					end
					mm_pkg::REG_INNER_DIM: begin
						inner_dim_q  <= pwdata[mm_pkg::DIM_W-1:0];
						load_count_q <= '0;
					end
					mm_pkg::REG_COLS_B: begin
						cols_b_q     <= pwdata[mm_pkg::DIM_W-1:0];
						load_count_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (accept) begin
				load_count_q <= final_elem ? '0 : LW'(pos + 1'b1);
			end
			if (accept && final_elem) begin
				busy_q <= 1'b1;
			end else if (out_valid && last) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;

	mm_ram #(
		.DEPTH(DEPTH),
		.WIDTH(ELEMENT_WIDTH)
	) u_store_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(pos[AW-1:0]),
		.wdata(element),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	mm_ram #(
		.DEPTH(DEPTH),
		.WIDTH(ELEMENT_WIDTH)
	) u_store_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(bpos[AW-1:0]),
		.wdata(element),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	mm_engine #(
		.MAX_DIM      (MAX_DIM),
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept && final_elem),
		.dims         (dims),
		.a_addr       (a_raddr),
		.b_addr       (b_raddr),
		.a_data       (a_rdata),
		.b_data       (b_rdata),
		.out_valid    (out_valid),
		.product_value(product_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.last         (last)
	);

endmodule

FILE: test/matrix_multiply_checker.sv
// ----------------------------------------------------------------------------
// matrix_multiply_checker
// Watches the config port, the element transfers and the result strobes of
// the matrix multiply block. It keeps its own copy of the dimension registers
// and element stores, works out every element of C when a load completes,
// and compares each result transfer against the oldest expected element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_multiply_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [3:0]                   paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         start,
	input  logic                         busy,
	input  logic [15:0]                  element,
	input  logic                         out_valid,
	input  logic [mm_pkg::VALUE_W-1:0]   product_value,
	input  logic [mm_pkg::IDX_W-1:0]     out_row,
	input  logic [mm_pkg::IDX_W-1:0]     out_col,
	input  logic                         last,
	output int                           error_count,
	output int                           results_owed
);
	import mm_pkg::*;

	localparam int SIDE   = 8;
	localparam int DEPTH  = SIDE * SIDE;
	localparam int ELEM_W = 16;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic               fin;
	} c_entry_t;

	logic [DIM_W-1:0]         rows_reg, inner_reg, cols_reg;
	logic signed [ELEM_W-1:0] a_mem [DEPTH];
	logic signed [ELEM_W-1:0] b_mem [DEPTH];
	int                       load_pos;
	int                       errors;
	c_entry_t                 c_due [$];

	function automatic int eff_dim(input logic [DIM_W-1:0] v);
		if (v < DIM_W'(2)) begin
			return 2;
		end
		if (v > DIM_W'(SIDE)) begin
			return SIDE;
		end
		return int'(v);
	endfunction

	task automatic note(input string what, input logic [63:0] exp_v, input logic [63:0] got_v);
		errors++;
		$display("%0t: %s expected %0h got %0h", $time, what, exp_v, got_v);
	endtask

	// store one element; on the last element of B queue all of C
	task automatic take_element(input logic signed [ELEM_W-1:0] e);
		int       r, k, c, size_a, total, pos, i, j, t;
		longint   acc;
		c_entry_t ce;
		r      = eff_dim(rows_reg);
		k      = eff_dim(inner_reg);
		c      = eff_dim(cols_reg);
		size_a = r * k;
		total  = size_a + k * c;
		pos    = load_pos;
		if (pos >= total) begin
			pos = 0;
		end
		if (pos < size_a) begin
			a_mem[pos] = e;
		end else begin
			b_mem[pos - size_a] = e;
		end
		if (pos + 1 < total) begin
			load_pos = pos + 1;
			return;
		end
		load_pos = 0;
		for (i = 0; i < r; i++) begin
			for (j = 0; j < c; j++) begin
				acc = 0;
				for (t = 0; t < k; t++) begin
					acc += longint'(a_mem[i * k + t]) * longint'(b_mem[t * c + j]);
				end
				ce.value = acc[VALUE_W-1:0];
				ce.row   = i[IDX_W-1:0];
				ce.col   = j[IDX_W-1:0];
				ce.fin   = (i == r - 1) && (j == c - 1);
				c_due.push_back(ce);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		c_entry_t ce;
		if (!arst_n) begin
			rows_reg  = DIM_W'(8);
			inner_reg = DIM_W'(8);
			cols_reg  = DIM_W'(8);
			load_pos  = 0;
			errors    = 0;
			c_due.delete();
		end else begin
			if (out_valid) begin
				if (c_due.size() == 0) begin
					note("result transfer with nothing due, value", 64'(0), 64'(product_value));
				end else begin
					ce = c_due.pop_front();
					if (product_value !== ce.value) begin
						note("product_value", 64'(ce.value), 64'(product_value));
					end
					if (out_row !== ce.row) begin
						note("out_row", 64'(ce.row), 64'(out_row));
					end
					if (out_col !== ce.col) begin
						note("out_col", 64'(ce.col), 64'(out_col));
					end
					if (last !== ce.fin) begin
						note("last", 64'(ce.fin), 64'(last));
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_ROWS_A: begin
						rows_reg = pwdata[DIM_W-1:0];
						load_pos = 0;
					end
					REG_INNER_DIM: begin
						inner_reg = pwdata[DIM_W-1:0];
						load_pos  = 0;
					end
					REG_COLS_B: begin
						cols_reg = pwdata[DIM_W-1:0];
						load_pos = 0;
					end
					default: begin
					end
				endcase
			end
			if (start && !busy) begin
				take_element(element);
			end
		end
		error_count  <= errors;
		results_owed <= c_due.size();
	end

endmodule

FILE: test/tb_matrix_multiply.sv
// ----------------------------------------------------------------------------
// tb_matrix_multiply
// Drives the matrix multiply block: dimension writes over the APB port while
// idle, then A and B loads with directed corner values followed by random
// dimensions and content, including cut-off loads, spare-register writes
// and random start gaps. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_matrix_multiply;
	import mm_pkg::*;

	localparam int         QUIET_LIMIT = 3000;
	localparam int         RAND_ITEMS  = 100;
	localparam logic [1:0] REG_SPARE   = 2'd3;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [3:0]                paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      start;
	logic signed [15:0]        element;
	logic                      busy;
	logic                      out_valid;
	logic signed [VALUE_W-1:0] product_value;
	logic [IDX_W-1:0]          out_row;
	logic [IDX_W-1:0]          out_col;
	logic                      last;

	int               error_count;
	int               results_owed;
	int               quiet;
	int               items_sent;
	logic [DIM_W-1:0] dim_reg [3];
	logic [15:0]      corner_load [8] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
		16'h8000, 16'h7FFF, 16'h8000, 16'h0000};

	matrix_multiply DUT (.*);

	matrix_multiply_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.start         (start),
		.busy          (busy),
		.element       (element),
		.out_valid     (out_valid),
		.product_value (product_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.last          (last),
		.error_count   (error_count),
		.results_owed  (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// no transfer of any kind for too long means the block is stuck
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int eff(input logic [DIM_W-1:0] v);
		if (v < DIM_W'(2)) begin
			return 2;
		end
		return (v > DIM_W'(8)) ? 8 : int'(v);
	endfunction

	function automatic int load_len();
		int k;
		k = eff(dim_reg[1]);
		return k * (eff(dim_reg[0]) + eff(dim_reg[2]));
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) begin
			return 0;
		end
		if (p < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// mostly small sizes, now and then the largest or an out-of-range code
	function automatic logic [DIM_W-1:0] pick_dim();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65) begin
			return DIM_W'($urandom_range(2, 3));
		end
		if (p < 85) begin
			return DIM_W'($urandom_range(4, 7));
		end
		if (p < 93) begin
			return DIM_W'(8);
		end
		return $urandom_range(0, 1) ? DIM_W'($urandom_range(0, 1)) : DIM_W'($urandom_range(9, 15));
	endfunction

	function automatic logic [15:0] make_elem(input int mode);
		case (mode)
			0: return 16'($urandom());
			1: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'hFFFF;
					3: return 16'h0001;
					default: return 16'h0000;
				endcase
			end
			2: return 16'($urandom_range(0, 511) - 256);
			default: return 16'h8000;
		endcase
	endfunction

	task automatic feed(input logic [15:0] v, input bit no_gaps);
		int g;
		g = no_gaps ? 0 : gap_len();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
		start   <= 1'b1;
		element <= v;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic send_load(input int mode, input bit no_gaps, input int count);
		for (int n = 0; n < count; n++) begin
			feed(make_elem(mode), no_gaps);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (results_owed != 0 || busy);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
		wait_idle();
		case (idx)
			REG_ROWS_A:    dim_reg[0] = data[DIM_W-1:0];
			REG_INNER_DIM: dim_reg[1] = data[DIM_W-1:0];
			REG_COLS_B:    dim_reg[2] = data[DIM_W-1:0];
			default: begin
			end
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] dim_word(input logic [DIM_W-1:0] v);
		logic [31:0] w;
		w = $urandom();
		w[DIM_W-1:0] = v;
		return w;
	endfunction

	initial begin
		int  total, n, mode;
		bit  no_gaps, need_cfg;
		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		start   <= 1'b0;
		element <= '0;
		items_sent = 0;
		dim_reg = '{DIM_W'(8), DIM_W'(8), DIM_W'(8)};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x2x2 with the extreme codes, low codes clamping up to 2
		cfg_write(REG_ROWS_A, 32'hFFFF_FFF2);
		cfg_write(REG_INNER_DIM, 32'h0000_0001);
		cfg_write(REG_COLS_B, 32'h0000_0000);
		foreach (corner_load[i]) begin
			feed(corner_load[i], 1'b1);
		end

		// spare register write mid-load must not restart the load
		for (int i = 0; i < 3; i++) begin
			feed(corner_load[7 - i], 1'b0);
		end
		cfg_write(REG_SPARE, 32'hFFFF_FFFF);
		for (int i = 3; i < 8; i++) begin
			feed(corner_load[7 - i], 1'b0);
		end

		// real register write mid-load restarts with A
		for (int i = 0; i < 3; i++) begin
			feed(16'h5555, 1'b0);
		end
		cfg_write(REG_COLS_B, 32'h0000_0002);
		for (int i = 0; i < 8; i++) begin
			feed(i[0] ? 16'hAAAA : 16'h5555, 1'b0);
		end

		// widest result (8x8 from a 2-deep product) and deepest sum of extremes
		cfg_write(REG_ROWS_A, dim_word(DIM_W'(9)));
		cfg_write(REG_INNER_DIM, dim_word(DIM_W'(2)));
		cfg_write(REG_COLS_B, dim_word(DIM_W'(8)));
		total = load_len();
		send_load(0, 1'b0, total);
		cfg_write(REG_ROWS_A, dim_word(DIM_W'(2)));
		cfg_write(REG_INNER_DIM, dim_word(DIM_W'(15)));
		cfg_write(REG_COLS_B, dim_word(DIM_W'(2)));
		total = load_len();
		send_load(3, 1'b0, total);

		need_cfg = 1'b1;
		while (items_sent < RAND_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if (need_cfg || $urandom_range(0, 9) < 6) begin
				if ($urandom_range(0, 9) < 3) begin
					case ($urandom_range(0, 2))
						0: cfg_write(REG_ROWS_A, dim_word(pick_dim()));
						1: cfg_write(REG_INNER_DIM, dim_word(pick_dim()));
						default: cfg_write(REG_COLS_B, dim_word(pick_dim()));
					endcase
				end else begin
					cfg_write(REG_ROWS_A, dim_word(pick_dim()));
					cfg_write(REG_INNER_DIM, dim_word(pick_dim()));
					cfg_write(REG_COLS_B, dim_word(pick_dim()));
				end
				need_cfg = 1'b0;
			end
			if ($urandom_range(0, 9) == 0) begin
				cfg_write(REG_SPARE, $urandom());
			end
			total = load_len();
			mode  = $urandom_range(0, 2);
			if ($urandom_range(0, 6) == 0) begin
				n = $urandom_range(1, total - 1);
				send_load(mode, no_gaps, n);
				need_cfg = 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, total - 1);
				send_load(mode, no_gaps, n);
				cfg_write(REG_SPARE, $urandom());
				send_load(mode, no_gaps, total - n);
			end else begin
				send_load(mode, no_gaps, total);
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (results_owed != 0 || busy);
		repeat (16) @(posedge clk);
		if (error_count == 0 && results_owed == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/mm_pkg.sv
design/mm_ram.sv
design/mm_engine.sv
design/matrix_multiply.sv
test/matrix_multiply_checker.sv
test/tb_matrix_multiply.sv
